@@ rtl/core/nested_interval_profiler_unit_macros.svh @@
// ----------------------------------------------------------------------------
// nested interval profiler assertion macros
// shared concurrent check forms, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef NESTED_INTERVAL_PROFILER_UNIT_MACROS_SVH
`define NESTED_INTERVAL_PROFILER_UNIT_MACROS_SVH

// same-cycle implication
`define NIP_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define NIP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/nip_pkg.sv @@
// ----------------------------------------------------------------------------
// nip_pkg
// shared types and codes of the nested interval profiler
// ----------------------------------------------------------------------------
package nip_pkg;

  localparam int CNT_W = 7;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_NO_BEGIN = 2'd1;
  localparam logic [1:0] ERR_NEST_OVF = 2'd2;

  localparam logic [1:0] CFG_SELF_COST = 2'd0;
  localparam logic [1:0] CFG_LOG_CAP   = 2'd1;

  // one event in flight through the pipeline
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  ridx;
    logic        finish;
    logic [31:0] ticks;
    logic [1:0]  err;
    logic        done;
    logic [31:0] count;
  } item_t;

  typedef struct packed {
    logic [31:0]      log_value;
    logic [CNT_W-1:0] logged_count;
    logic [CNT_W-1:0] longest_position;
    logic [CNT_W-1:0] shortest_position;
    logic [31:0]      longest_ticks;
    logic [31:0]      shortest_ticks;
    logic [47:0]      total_ticks;
    logic [31:0]      entry_count;
    logic [1:0]       error_code;
    logic             outermost_done;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [CNT_W-1:0]      fill;
    logic [31:0]           data;
  } wr_t;

endpackage

@@ rtl/core/nested_interval_profiler_unit.sv @@
// a result is registered through the track, clamp and stats stages after its input transfer
// throughput: one event per cycle while the result output is not stalled; the log ram takes
// one write and one read each cycle, and a read that meets a same-entry write in that cycle is forwarded
// reset: rst_ni clears the configuration, nesting, statistics, log fill and all valids;
// log contents stay undefined and are never returned before being written
`include "nested_interval_profiler_unit_macros.svh"
// ----------------------------------------------------------------------------
// nested_interval_profiler_unit
// timestamped begin/end/clear/read profiler for one measured region
// ----------------------------------------------------------------------------
module nested_interval_profiler_unit #(
  parameter int LOG_DEPTH = 64,
  parameter int MAX_NEST  = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // timestamp[31:0], read_index[37:32], zero fill to 40 bits
  input  logic [39:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // outermost_done[0], error_code[2:1], entry_count[34:3], total_ticks[82:35],
  // shortest_ticks[114:83], longest_ticks[146:115], shortest_position[153:147],
  // longest_position[160:154], logged_count[167:161], log_value[199:168]
  output logic [199:0] m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import nip_pkg::*;

  localparam int AddrW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  logic [31:0]      self_cost_q;
  logic [CNT_W-1:0] log_cap_q;

  item_t s0_item, s1_q, s2_q, s2_in;
  logic  s1_v_q, s2_v_q, o_v_q;
  res_t  res, out_q;
  wr_t   wr;
  logic  accept, adv1, adv2, s2_free;
  logic [31:0] rd_data;
  logic [32:0] diff;
  logic [AddrW+CNT_W-1:0] waddr_ext;
  logic [AddrW+5:0]       raddr_ext;

  // config
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_cost_q <= '0;
      log_cap_q   <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SELF_COST) self_cost_q <= cfg_data_i;
      if (cfg_index_i == CFG_LOG_CAP)   log_cap_q   <= cfg_data_i[CNT_W-1:0];
    end
  end

  // pipeline flow control
  assign adv2            = s2_v_q && (!o_v_q || m_axis_tready_i);
  assign s2_free         = !s2_v_q || adv2;
  assign adv1            = s1_v_q && s2_free;
  assign s_axis_tready_o = !s1_v_q || adv1;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  nip_track #(
    .MAX_NEST(MAX_NEST)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .op_i    (s_axis_tuser_i),
    .ts_i    (s_axis_tdata_i[31:0]),
    .ridx_i  (s_axis_tdata_i[37:32]),
    .item_o  (s0_item)
  );

  // self-cost subtraction, clamped at zero
  assign diff = {1'b0, s1_q.ticks} - {1'b0, self_cost_q};
  always_comb begin
    s2_in       = s1_q;
    s2_in.ticks = diff[32] ? 32'd0 : diff[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= s0_item;
    if (adv1)   s2_q <= s2_in;
    if (adv2)   out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s_axis_tready_o) s1_v_q <= s_axis_tvalid_i;
      if (s2_free)         s2_v_q <= s1_v_q;
      if (!o_v_q || m_axis_tready_i) o_v_q <= s2_v_q;
    end
  end

  nip_stats #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv2),
    .item_i   (s2_q),
    .log_cap_i(log_cap_q),
    .rd_data_i(rd_data),
    .wr_o     (wr),
    .res_o    (res)
  );

  assign waddr_ext = {{AddrW{1'b0}}, wr.fill};
  assign raddr_ext = {{AddrW{1'b0}}, s1_q.ridx};

  nip_log_ram #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_log_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (wr.we),
    .waddr_i(waddr_ext[AddrW-1:0]),
    .wdata_i(wr.data),
    .re_i   (adv1),
    .raddr_i(raddr_ext[AddrW-1:0]),
    .rdata_o(rd_data)
  );

  assign m_axis_tvalid_o = o_v_q;
  assign m_axis_tdata_o  = out_q;

  `NIP_ASSERT_SAME(a_no_begin_done, o_v_q && (out_q.error_code == ERR_NO_BEGIN), out_q.outermost_done, "end without begin left nesting open")
  `NIP_ASSERT_SAME(a_fill_bound, o_v_q, out_q.logged_count <= CNT_W'((LOG_DEPTH > 127) ? 127 : LOG_DEPTH), "log fill beyond depth")
  `NIP_ASSERT_SAME(a_min_le_max, o_v_q && (out_q.shortest_ticks != '1), out_q.shortest_ticks <= out_q.longest_ticks, "shortest above longest")
  `NIP_ASSERT_NEXT(a_stage_move, adv1, s2_v_q, "item lost between stages")

endmodule

@@ rtl/core/nip_track.sv @@
// ----------------------------------------------------------------------------
// nip_track
// nesting depth, start tick and entry count, updated on every input transfer
// ----------------------------------------------------------------------------
module nip_track #(
  parameter int MAX_NEST = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [1:0]    op_i,
  input  logic [31:0]   ts_i,
  input  logic [5:0]    ridx_i,
  output nip_pkg::item_t item_o
);
  import nip_pkg::*;

  localparam int NestW = $clog2(MAX_NEST + 1);
  localparam logic [NestW-1:0] NestMax = NestW'(MAX_NEST);
  localparam logic [NestW-1:0] NestOne = NestW'(1);

  logic [NestW-1:0] nest_q, nest_d;
  logic [31:0]      start_q, start_d;
  logic [31:0]      count_q, count_d;
  logic [1:0]       err;
  logic             finish;

  always_comb begin
    nest_d  = nest_q;
    start_d = start_q;
    count_d = count_q;
    err     = ERR_OK;
    finish  = 1'b0;
    unique case (op_i)
      OP_BEGIN: begin
        if (nest_q == NestMax) begin
          err = ERR_NEST_OVF;
        end else begin
          if (count_q != '1) count_d = count_q + 32'd1;
          if (nest_q == '0) start_d = ts_i;
          nest_d = nest_q + NestOne;
        end
      end
      OP_END: begin
        if (nest_q == '0) begin
          err = ERR_NO_BEGIN;
        end else begin
          nest_d = nest_q - NestOne;
          finish = (nest_q == NestOne) && (count_q != '0);
        end
      end
      OP_CLEAR: begin
        nest_d  = '0;
        start_d = '0;
        count_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    item_o.op     = op_i;
    item_o.ridx   = ridx_i;
    item_o.finish = finish;
    item_o.ticks  = ts_i - start_q;   // raw elapsed, wraps mod 2^32
    item_o.err    = err;
    item_o.done   = (nest_d == '0);
    item_o.count  = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nest_q  <= '0;
      start_q <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      nest_q  <= nest_d;
      start_q <= start_d;
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/core/nip_log_ram.sv @@
// ----------------------------------------------------------------------------
// nip_log_ram
// interval log memory, one write and one registered read port, write forwarding
// ----------------------------------------------------------------------------
module nip_log_ram #(
  parameter int LOG_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [((LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1)-1:0] waddr_i,
  input  logic [31:0] wdata_i,
  input  logic        re_i,
  input  logic [((LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1)-1:0] raddr_i,
  output logic [31:0] rdata_o
);
  localparam int AddrW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  logic [31:0] mem [LOG_DEPTH];
  logic [31:0] rd_q;
  logic [31:0] fwd_data_q;
  logic        fwd_q;
  logic [AddrW-1:0] unused_chk;

  assign unused_chk = raddr_i;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  // a read issued alongside a write to the same entry takes the new value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (re_i) begin
      fwd_q <= we_i && (waddr_i == unused_chk);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

@@ rtl/core/nip_stats.sv @@
// ----------------------------------------------------------------------------
// nip_stats
// running total, extremes and log fill; builds the result of each event
// ----------------------------------------------------------------------------
module nip_stats #(
  parameter int LOG_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  nip_pkg::item_t           item_i,
  input  logic [nip_pkg::CNT_W-1:0] log_cap_i,
  input  logic [31:0]              rd_data_i,
  output nip_pkg::wr_t             wr_o,
  output nip_pkg::res_t            res_o
);
  import nip_pkg::*;

  localparam logic [CNT_W-1:0] DepthCap = CNT_W'((LOG_DEPTH > 127) ? 127 : LOG_DEPTH);

  logic [47:0]      sum_q, sum_d;
  logic [31:0]      min_q, min_d, max_q, max_d;
  logic [CNT_W-1:0] min_pos_q, min_pos_d, max_pos_q, max_pos_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cap;
  logic             append;
  logic             rd_hit;

  assign cap    = (log_cap_i > DepthCap) ? DepthCap : log_cap_i;
  assign append = item_i.finish && (fill_q < cap);

  always_comb begin
    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    min_pos_d = min_pos_q;
    max_pos_d = max_pos_q;
    fill_d    = fill_q;
    if (item_i.op == OP_CLEAR) begin
      sum_d     = '0;
      min_d     = '1;
      max_d     = '0;
      min_pos_d = '0;
      max_pos_d = '0;
      fill_d    = '0;
    end else if (item_i.finish) begin
      sum_d = sum_q + {16'd0, item_i.ticks};
      if (item_i.ticks < min_q) begin
        min_d     = item_i.ticks;
        min_pos_d = fill_q;
      end
      if (item_i.ticks > max_q) begin
        max_d     = item_i.ticks;
        max_pos_d = fill_q;
      end
      if (append) fill_d = fill_q + CNT_W'(1);
    end
  end

  // fill already counts every earlier append, so this bound keeps out unwritten entries
  assign rd_hit = (item_i.op == OP_READ) && ({1'b0, item_i.ridx} < fill_q);

  always_comb begin
    wr_o.we   = en_i && append;
    wr_o.fill = fill_q;
    wr_o.data = item_i.ticks;
  end

  always_comb begin
    res_o.outermost_done    = item_i.done;
    res_o.error_code        = item_i.err;
    res_o.entry_count       = item_i.count;
    res_o.total_ticks       = sum_d;
    res_o.shortest_ticks    = min_d;
    res_o.longest_ticks     = max_d;
    res_o.shortest_position = min_pos_d;
    res_o.longest_position  = max_pos_d;
    res_o.logged_count      = fill_d;
    res_o.log_value         = rd_hit ? rd_data_i : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      min_q     <= '1;
      max_q     <= '0;
      min_pos_q <= '0;
      max_pos_q <= '0;
      fill_q    <= '0;
    end else if (en_i) begin
      sum_q     <= sum_d;
      min_q     <= min_d;
      max_q     <= max_d;
      min_pos_q <= min_pos_d;
      max_pos_q <= max_pos_d;
      fill_q    <= fill_d;
    end
  end

endmodule

@@ bench/nip_profile_check.sv @@
// ----------------------------------------------------------------------------
// nip_profile_check
// watches the event, result and register channels of the interval profiler,
// keeps its own copy of the nesting, statistics and log state, and compares
// every result transfer field by field against the oldest predicted result
// ----------------------------------------------------------------------------
module nip_profile_check
  import nip_pkg::*;
#(
  parameter int LOG_DEPTH = 64,
  parameter int MAX_NEST  = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [39:0]  s_tdata_i,
  input  logic [1:0]   s_tuser_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [199:0] m_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int           errors_o,
  output int           pending_o,
  output int           results_o,
  output int           flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] cost_q;
  logic [6:0]  cap_q;
  logic [7:0]  depth_q;
  logic [31:0] mark_q;
  logic [31:0] begins_q;
  logic [47:0] sum_q;
  logic [31:0] min_q;
  logic [31:0] max_q;
  logic [6:0]  min_at_q;
  logic [6:0]  max_at_q;
  logic [6:0]  fill_q;
  logic [31:0] log_q [LOG_DEPTH];
  res_t        stats_q [$];

  function automatic void reset_stats();
    depth_q  = '0;
    mark_q   = '0;
    begins_q = '0;
    sum_q    = '0;
    min_q    = '1;
    max_q    = '0;
    min_at_q = '0;
    max_at_q = '0;
    fill_q   = '0;
  endfunction

  function automatic res_t apply_event(logic [1:0] op, logic [31:0] stamp, logic [5:0] ridx);
    res_t        r;
    logic [31:0] span;
    int          limit;
    r = '0;
    r.error_code = ERR_OK;
    case (op)
      OP_BEGIN: begin
        if (depth_q >= MAX_NEST) begin
          r.error_code = ERR_NEST_OVF;
        end else begin
          if (begins_q != '1) begins_q = begins_q + 32'd1;
          if (depth_q == '0) mark_q = stamp;
          depth_q = depth_q + 8'd1;
        end
      end
      OP_END: begin
        if (depth_q == '0) begin
          r.error_code = ERR_NO_BEGIN;
        end else begin
          depth_q = depth_q - 8'd1;
          if (depth_q == '0 && begins_q != '0) begin
            // elapsed ticks wrap at 32 bits, overhead clamps at zero
            span = stamp - mark_q;
            span = (span < cost_q) ? 32'd0 : span - cost_q;
            sum_q = sum_q + {16'd0, span};
            if (span < min_q) begin
              min_q    = span;
              min_at_q = fill_q;
            end
            if (span > max_q) begin
              max_q    = span;
              max_at_q = fill_q;
            end
            limit = (cap_q > LOG_DEPTH) ? LOG_DEPTH : int'(cap_q);
            if (fill_q < limit) begin
              log_q[fill_q] = span;
              fill_q = fill_q + 7'd1;
            end
          end
        end
      end
      OP_CLEAR: reset_stats();
      default: begin
        if (ridx < fill_q) r.log_value = log_q[ridx];
      end
    endcase
    r.outermost_done    = (depth_q == '0);
    r.entry_count       = begins_q;
    r.total_ticks       = sum_q;
    r.shortest_ticks    = min_q;
    r.longest_ticks     = max_q;
    r.shortest_position = min_at_q;
    r.longest_position  = max_at_q;
    r.logged_count      = fill_q;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors_o++;
      $display("%0t ns: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      cost_q = '0;
      cap_q  = '0;
      reset_stats();
      stats_q.delete();
      pending_o = 0;
      errors_o  = 0;
      results_o = 0;
      flagged_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SELF_COST: cost_q = cfg_data_i;
          CFG_LOG_CAP:   cap_q  = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        stats_q.push_back(apply_event(s_tuser_i, s_tdata_i[31:0], s_tdata_i[37:32]));
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i);
        results_o++;
        if (got.error_code != ERR_OK) flagged_o++;
        if (stats_q.size() == 0) begin
          errors_o++;
          $display("%0t ns: result transfer with nothing expected, actual 0x%0h",
                   $time, m_tdata_i);
        end else begin
          want = stats_q.pop_front();
          check_field("outermost_done", want.outermost_done, got.outermost_done);
          check_field("error_code", want.error_code, got.error_code);
          check_field("entry_count", want.entry_count, got.entry_count);
          check_field("total_ticks", want.total_ticks, got.total_ticks);
          check_field("shortest_ticks", want.shortest_ticks, got.shortest_ticks);
          check_field("longest_ticks", want.longest_ticks, got.longest_ticks);
          check_field("shortest_position", want.shortest_position, got.shortest_position);
          check_field("longest_position", want.longest_position, got.longest_position);
          check_field("logged_count", want.logged_count, got.logged_count);
          check_field("log_value", want.log_value, got.log_value);
        end
      end
      pending_o = stats_q.size();
    end
  end

endmodule

@@ bench/nested_interval_profiler_unit_tb.sv @@
// ----------------------------------------------------------------------------
// nested_interval_profiler_unit_tb
// drives timestamped begin/end/clear/read events and register writes into the
// profiler with random gaps and back-pressure, including a long output stall;
// a separate monitor predicts and checks every result
// ----------------------------------------------------------------------------
module nested_interval_profiler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nip_pkg::*;

  localparam int LOG_DEPTH   = 64;
  localparam int MAX_NEST    = 255;
  localparam int HOLD_CYCLES = 64;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [39:0]  ev_data = '0;
  logic [1:0]   ev_op = OP_BEGIN;
  logic         ev_valid = 1'b0;
  logic         ev_ready;
  logic [199:0] res_data;
  logic         res_valid;
  logic         res_ready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = CFG_SELF_COST;
  logic [31:0]  cfg_data = '0;

  int          mismatches;
  int          outstanding;
  int          checked;
  int          flagged;
  int          sent = 0;
  int          settings = 0;
  int          open_cnt = 0;
  logic [31:0] tick = '0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_pending = 1'b0;

  nested_interval_profiler_unit #(
    .LOG_DEPTH(LOG_DEPTH),
    .MAX_NEST (MAX_NEST)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (ev_data),
    .s_axis_tuser_i (ev_op),
    .s_axis_tvalid_i(ev_valid),
    .s_axis_tready_o(ev_ready),
    .m_axis_tdata_o (res_data),
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  nip_profile_check #(
    .LOG_DEPTH(LOG_DEPTH),
    .MAX_NEST (MAX_NEST)
  ) u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tdata_i  (ev_data),
    .s_tuser_i  (ev_op),
    .s_tvalid_i (ev_valid),
    .s_tready_i (ev_ready),
    .m_tdata_i  (res_data),
    .m_tvalid_i (res_valid),
    .m_tready_i (res_ready),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (mismatches),
    .pending_o  (outstanding),
    .results_o  (checked),
    .flagged_o  (flagged)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        res_ready <= rst_n && (rx_quiet || ($urandom_range(99) >= 22));
      end
    end
  end

  function automatic logic [31:0] step_tick();
    case ($urandom_range(9))
      0:       tick = $urandom;
      1:       tick = tick + $urandom;
      default: tick = tick + $urandom_range(500);
    endcase
    return tick;
  endfunction

  task automatic push_event(logic [1:0] op, logic [31:0] stamp, logic [5:0] ridx);
    if (!tx_quiet) begin
      while ($urandom_range(99) < 22) begin
        ev_valid <= 1'b0;
        @(posedge clk);
      end
    end
    ev_valid <= 1'b1;
    ev_op    <= op;
    ev_data  <= {2'b00, ridx, stamp};
    do @(posedge clk); while (!ev_ready);
    sent++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic settle();
    ev_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] cost, logic [6:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SELF_COST;
    cfg_data  <= cost;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_LOG_CAP;
    cfg_data  <= {25'd0, cap};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // mostly balanced begin/end pairs with reads between, plus clears and noise
  task automatic random_events(int count, int clear_pct, int hold_at);
    int          roll;
    logic [1:0]  op;
    logic [31:0] stamp;
    bit          noisy;
    for (int k = 0; k < count; k++) begin
      if (hold_at >= 0) begin
        if (k == hold_at) begin
          hold_pending = 1'b1;
          tx_quiet     = 1'b1;
        end
        if (k == hold_at + 30) rx_quiet = 1'b1;
        if (k == hold_at + 80) begin
          tx_quiet = 1'b0;
          rx_quiet = 1'b0;
        end
      end
      roll  = $urandom_range(99);
      noisy = 1'b0;
      if (roll < clear_pct) begin
        op = OP_CLEAR;
      end else if (roll < clear_pct + 5) begin
        noisy = 1'b1;
        op    = 2'($urandom_range(3));
        if (op == OP_CLEAR && clear_pct == 0) op = OP_END;
      end else if (roll < clear_pct + 22) begin
        op = OP_READ;
      end else if (open_cnt == 0 || (open_cnt < 3 && roll < 60)) begin
        op = OP_BEGIN;
      end else begin
        op = OP_END;
      end
      stamp = noisy ? $urandom : step_tick();
      case (op)
        OP_BEGIN: open_cnt++;
        OP_END:   if (open_cnt > 0) open_cnt--;
        OP_CLEAR: open_cnt = 0;
        default: ;
      endcase
      push_event(op, stamp,
                 6'($urandom_range(1) ? $urandom_range(7) : $urandom_range(63)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // wrap-around, extreme spans, ties, nesting and reads with full log room
    program_regs(32'd0, 7'd64);
    push_event(OP_END,   32'd0,          6'd0);
    push_event(OP_READ,  32'd0,          6'd0);
    push_event(OP_BEGIN, 32'hFFFF_FFF0,  6'd0);
    push_event(OP_END,   32'h0000_0010,  6'd0);
    push_event(OP_BEGIN, 32'd0,          6'd0);
    push_event(OP_END,   32'hFFFF_FFFF,  6'd0);
    push_event(OP_BEGIN, 32'd5,          6'd0);
    push_event(OP_END,   32'd5,          6'd0);
    push_event(OP_BEGIN, 32'd10,         6'd0);
    push_event(OP_END,   32'd10,         6'd0);
    push_event(OP_BEGIN, 32'd0,          6'd0);
    push_event(OP_END,   32'hFFFF_FFFF,  6'd0);
    push_event(OP_BEGIN, 32'd100,        6'd0);
    push_event(OP_BEGIN, 32'd200,        6'd0);
    push_event(OP_END,   32'd300,        6'd0);
    push_event(OP_END,   32'd400,        6'd0);
    push_event(OP_READ,  32'd0,          6'd0);
    push_event(OP_READ,  32'd0,          6'd4);
    push_event(OP_READ,  32'd0,          6'd63);
    push_event(OP_READ,  32'd0,          6'd5);
    push_event(OP_CLEAR, 32'd0,          6'd0);
    push_event(OP_READ,  32'd0,          6'd0);
    settle();

    // overhead no smaller than any span clamps to zero, log of one fills at once
    program_regs(32'hFFFF_FFFF, 7'd1);
    push_event(OP_BEGIN, 32'd0,          6'd0);
    push_event(OP_END,   32'hFFFF_FFFF,  6'd0);
    push_event(OP_BEGIN, 32'd3,          6'd0);
    push_event(OP_END,   32'd1,          6'd0);
    push_event(OP_READ,  32'd0,          6'd0);
    push_event(OP_READ,  32'd0,          6'd1);
    settle();

    program_regs(32'd0, 7'd0);
    random_events(30, 3, -1);
    settle();

    program_regs($urandom_range(50), 7'd5);
    random_events(30, 3, -1);
    settle();

    // nest past the bound, unwind, then one unmatched end
    program_regs(32'd7, 7'd64);
    push_event(OP_CLEAR, tick, 6'd0);
    open_cnt = 0;
    repeat (MAX_NEST + 2) push_event(OP_BEGIN, step_tick(), 6'($urandom_range(63)));
    repeat (MAX_NEST + 1) push_event(OP_END, step_tick(), 6'($urandom_range(63)));
    random_events(10, 3, -1);
    settle();

    // no clears, one long output hold-off; capacity above the store acts as its depth
    program_regs($urandom_range(40), 7'd127);
    push_event(OP_CLEAR, tick, 6'd0);
    open_cnt = 0;
    random_events(100, 0, 10);
    settle();

    repeat (8) @(posedge clk);
    $display("%0d events over %0d register settings, %0d results checked, %0d carrying errors",
             sent, settings, checked, flagged);
    $display("included wrapped spans, clamped overhead, nesting overflow, full logs, clears");
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
